>>> rtl/bsc_pkg.sv
// ---------------------------------------------------------------------------
// Barometric sensor compensation package
// Shared types, constants and helper functions for the compensation block.
// ---------------------------------------------------------------------------
package bsc_pkg;

  // Field widths.
  localparam int unsigned RawW   = 16;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AC1   = 3'd0,
    CFG_AC2   = 3'd1,
    CFG_AC3   = 3'd2,
    CFG_AC4   = 3'd3,
    CFG_AC5   = 3'd4,
    CFG_AC6   = 3'd5,
    CFG_B1_B2 = 3'd6,
    CFG_MC_MD = 3'd7
  } cfg_idx_e;

  // Item kinds.
  localparam logic ACT_TEMP  = 1'b0;
  localparam logic ACT_PRESS = 1'b1;

  // Compensation constants.
  localparam logic [ValW-1:0] B6_OFFSET   = 32'd4000;
  localparam logic [ValW-1:0] X3_BIAS     = 32'd32768;
  localparam logic [ValW-1:0] B7_SCALE    = 32'd50000;
  localparam logic [ValW-1:0] P_SQ_COEFF  = 32'd3038;
  localparam logic [ValW-1:0] P_LIN_COEFF = 32'hFFFF_E343;  // -7357
  localparam logic [ValW-1:0] P_OFFSET    = 32'd3791;
  localparam logic [ValW-1:0] T_ROUND     = 32'd8;
  localparam logic [ValW-1:0] Q_ROUND     = 32'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_CHK,
    ST_T_DIV,
    ST_T_FIN,
    ST_P_B6,
    ST_P_SQ,
    ST_P_X1,
    ST_P_X2,
    ST_P_B3,
    ST_P_X1B,
    ST_P_X2B,
    ST_P_X3,
    ST_P_B4,
    ST_P_B7,
    ST_P_CHK,
    ST_P_DIV,
    ST_P_S1,
    ST_P_S2,
    ST_P_S3,
    ST_P_FIN
  } bsc_state_e;

  // Divider control and status.
  typedef struct packed {
    logic start;
    logic signed_op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sign-extend a 16-bit coefficient to 32 bits.
  function automatic logic [ValW-1:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [ValW-1:0] asr32(input logic [ValW-1:0] x,
                                            input logic [4:0] n);
    return ValW'($signed(x) >>> n);
  endfunction

endpackage

>>> rtl/bsc_intf.sv
// ---------------------------------------------------------------------------
// Barometric sensor compensation channel interfaces
// Valid/ready channels for raw readings, results and configuration writes.
// ---------------------------------------------------------------------------

// Raw reading channel.
interface bsc_in_if;
  import bsc_pkg::*;
  logic            valid;
  logic            ready;
  logic            action;
  logic [RawW-1:0] raw_reading;

  modport source (output valid, action, raw_reading, input ready);
  modport sink   (input valid, action, raw_reading, output ready);
endinterface

// Compensated result channel.
interface bsc_out_if;
  import bsc_pkg::*;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ValW-1:0] value;
  logic            div_error;

  modport source (output valid, kind, value, div_error, input ready);
  modport sink   (input valid, kind, value, div_error, output ready);
endinterface

// Configuration write channel.
interface bsc_cfg_if;
  import bsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bsc_div.sv
// ---------------------------------------------------------------------------
// Barometric sensor compensation divider
// Radix-2 restoring divider, one quotient bit per cycle, with optional
// signed operands (truncating toward zero).
// ---------------------------------------------------------------------------
module bsc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bsc_pkg::div_req_t      req_i,
  input  logic [bsc_pkg::ValW-1:0] dividend_i,
  input  logic [bsc_pkg::ValW-1:0] divisor_i,
  output bsc_pkg::div_stat_t     stat_o,
  output logic [bsc_pkg::ValW-1:0] quotient_o
);
  import bsc_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [ValW-1:0] rem_q, rem_d;
  logic [ValW-1:0] quo_q, quo_d;
  logic [ValW-1:0] dvs_q, dvs_d;
  logic            neg_q, neg_d;

  logic            neg_a, neg_b;
  logic [ValW-1:0] mag_a, mag_b;
  logic [ValW:0]   rem_sh;
  logic [ValW+1:0] diff;

  // Operand magnitudes for a signed start.
  assign neg_a = req_i.signed_op & dividend_i[ValW-1];
  assign neg_b = req_i.signed_op & divisor_i[ValW-1];
  assign mag_a = neg_a ? (ValW'(0) - dividend_i) : dividend_i;
  assign mag_b = neg_b ? (ValW'(0) - divisor_i) : divisor_i;

  // Trial subtraction for the next quotient bit.
  assign rem_sh = {rem_q, quo_q[ValW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  // Step control.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = mag_a;
      dvs_d  = mag_b;
      neg_d  = neg_a ^ neg_b;
    end else if (busy_q) begin
      if (!diff[ValW+1]) begin
        rem_d = diff[ValW-1:0];
        quo_d = {quo_q[ValW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[ValW-1:0];
        quo_d = {quo_q[ValW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(ValW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = neg_q ? (ValW'(0) - quo_q) : quo_q;

endmodule

>>> rtl/barometric_sensor_compensation_top.sv
// ---------------------------------------------------------------------------
// Barometric sensor compensation
// Applies the integer calibration to raw temperature and pressure readings
// with one shared multiplier and one iterative divider under a sequencer.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload                      Role
//   in_i     sink       action, raw_reading          raw conversion result
//   out_o    source     kind, value, div_error       compensated result
//   cfg_i    sink       index, data                  calibration register write
//
// A temperature item steps through ST_T_MUL to ST_T_FIN and a pressure item
// through ST_P_B6 to ST_P_FIN, each with a divide; a zero divisor ends the
// item in the check state. The next item is accepted in the cycle after the
// result is written, even while that result waits in the output register. A
// full output register holds the sequencer in its final or check state.
// Reset clears the calibration registers, the stored temperature term and
// all control state; configuration writes are taken in every cycle.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation_top (
  input logic      clk_i,
  input logic      rst_ni,
  bsc_in_if.sink   in_i,
  bsc_out_if.source out_o,
  bsc_cfg_if.sink  cfg_i
);
  import bsc_pkg::*;

  // Calibration registers.
  logic [15:0]     ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
  logic [ValW-1:0] b1b2_q, mcmd_q;

  // Sequencer and datapath registers.
  bsc_state_e      state_q, state_d;
  logic [ValW-1:0] temp_term_q, temp_term_d;
  logic [RawW-1:0] raw_q, raw_d;
  logic [ValW-1:0] b6_q, b6_d;
  logic [ValW-1:0] sq_q, sq_d;
  logic [ValW-1:0] t1_q, t1_d;
  logic [ValW-1:0] t2_q, t2_d;
  logic [ValW-1:0] b3_q, b3_d;
  logic [ValW-1:0] b4_q, b4_d;
  logic [ValW-1:0] p_q, p_d;
  logic            post_sh_q, post_sh_d;

  // Output register.
  logic            out_valid_q;
  logic            out_kind_q;
  logic [ValW-1:0] out_value_q;
  logic            out_err_q;

  // Shared multiplier, low word of the product only.
  logic [ValW-1:0] mul_a, mul_b, mul_p;

  // Divider hookup.
  div_req_t        div_req;
  div_stat_t       div_stat;
  logic [ValW-1:0] div_a, div_b, div_q;

  // Result emission.
  logic            emit;
  logic            emit_kind;
  logic [ValW-1:0] emit_val;
  logic            emit_err;

  logic            out_free;
  logic [ValW-1:0] den;
  logic            den_zero;
  logic            b4_zero;
  logic [ValW-1:0] b5;

  assign mul_p    = mul_a * mul_b;

  assign out_free = !out_valid_q || out_o.ready;
  assign den      = t1_q + sx16(mcmd_q[15:0]);
  assign den_zero = (den == '0);
  assign b4_zero  = (b4_q == '0);
  assign b5       = t1_q + t2_q;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  bsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .stat_o     (div_stat),
    .quotient_o (div_q)
  );

  // Calibration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q  <= '0;
      ac2_q  <= '0;
      ac3_q  <= '0;
      ac4_q  <= '0;
      ac5_q  <= '0;
      ac6_q  <= '0;
      b1b2_q <= '0;
      mcmd_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_AC1:   ac1_q  <= cfg_i.data[15:0];
        CFG_AC2:   ac2_q  <= cfg_i.data[15:0];
        CFG_AC3:   ac3_q  <= cfg_i.data[15:0];
        CFG_AC4:   ac4_q  <= cfg_i.data[15:0];
        CFG_AC5:   ac5_q  <= cfg_i.data[15:0];
        CFG_AC6:   ac6_q  <= cfg_i.data[15:0];
        CFG_B1_B2: b1b2_q <= cfg_i.data;
        CFG_MC_MD: mcmd_q <= cfg_i.data;
        default:   ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = (in_i.action == ACT_PRESS) ? ST_P_B6 : ST_T_MUL;
      ST_T_MUL: state_d = ST_T_CHK;
      ST_T_CHK: begin
        if (!den_zero) state_d = ST_T_DIV;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_T_DIV: if (div_stat.done) state_d = ST_T_FIN;
      ST_T_FIN: if (out_free) state_d = ST_IDLE;
      ST_P_B6:  state_d = ST_P_SQ;
      ST_P_SQ:  state_d = ST_P_X1;
      ST_P_X1:  state_d = ST_P_X2;
      ST_P_X2:  state_d = ST_P_B3;
      ST_P_B3:  state_d = ST_P_X1B;
      ST_P_X1B: state_d = ST_P_X2B;
      ST_P_X2B: state_d = ST_P_X3;
      ST_P_X3:  state_d = ST_P_B4;
      ST_P_B4:  state_d = ST_P_B7;
      ST_P_B7:  state_d = ST_P_CHK;
      ST_P_CHK: begin
        if (!b4_zero) state_d = ST_P_DIV;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_P_DIV: if (div_stat.done) state_d = ST_P_S1;
      ST_P_S1:  state_d = ST_P_S2;
      ST_P_S2:  state_d = ST_P_S3;
      ST_P_S3:  state_d = ST_P_FIN;
      ST_P_FIN: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: operand selection, register loads and result emission.
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    div_a       = '0;
    div_b       = '0;
    emit        = 1'b0;
    emit_kind   = ACT_TEMP;
    emit_val    = '0;
    emit_err    = 1'b0;
    temp_term_d = temp_term_q;
    raw_d       = raw_q;
    b6_d        = b6_q;
    sq_d        = sq_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    b3_d        = b3_q;
    b4_d        = b4_q;
    p_d         = p_q;
    post_sh_d   = post_sh_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) raw_d = in_i.raw_reading;
      end
      // x1 = ((ut - ac6) * ac5) >> 15
      ST_T_MUL: begin
        mul_a = {16'b0, raw_q} - {16'b0, ac6_q};
        mul_b = {16'b0, ac5_q};
        t1_d  = asr32(mul_p, 5'd15);
      end
      // Zero divisor check, else start the signed division (mc << 11) / den.
      ST_T_CHK: begin
        if (den_zero) begin
          emit      = out_free;
          emit_kind = ACT_TEMP;
          emit_err  = 1'b1;
        end else begin
          div_req.start     = 1'b1;
          div_req.signed_op = 1'b1;
          div_a             = sx16(mcmd_q[31:16]) << 11;
          div_b             = den;
        end
      end
      ST_T_DIV: begin
        if (div_stat.done) t2_d = div_q;
      end
      // b5 = x1 + x2 is kept for later pressure items.
      ST_T_FIN: begin
        emit      = out_free;
        emit_kind = ACT_TEMP;
        emit_val  = asr32(b5 + T_ROUND, 5'd4);
        if (out_free) temp_term_d = b5;
      end
      ST_P_B6: b6_d = temp_term_q - B6_OFFSET;
      ST_P_SQ: begin
        mul_a = b6_q;
        mul_b = b6_q;
        sq_d  = asr32(mul_p, 5'd12);
      end
      ST_P_X1: begin
        mul_a = sx16(b1b2_q[15:0]);
        mul_b = sq_q;
        t1_d  = asr32(mul_p, 5'd11);
      end
      ST_P_X2: begin
        mul_a = sx16(ac2_q);
        mul_b = b6_q;
        t2_d  = asr32(mul_p, 5'd11);
      end
      ST_P_B3: b3_d = asr32((sx16(ac1_q) << 2) + t1_q + t2_q + Q_ROUND, 5'd2);
      ST_P_X1B: begin
        mul_a = sx16(ac3_q);
        mul_b = b6_q;
        t1_d  = asr32(mul_p, 5'd13);
      end
      ST_P_X2B: begin
        mul_a = sx16(b1b2_q[31:16]);
        mul_b = sq_q;
        t2_d  = asr32(mul_p, 5'd16);
      end
      // Keeps x3 + 32768 for the scale product.
      ST_P_X3: t1_d = asr32(t1_q + t2_q + Q_ROUND, 5'd2) + X3_BIAS;
      ST_P_B4: begin
        mul_a = {16'b0, ac4_q};
        mul_b = t1_q;
        b4_d  = mul_p >> 15;
      end
      ST_P_B7: begin
        mul_a = {16'b0, raw_q} - b3_q;
        mul_b = B7_SCALE;
        t2_d  = mul_p;
      end
      // The doubling of b7 goes before or after the divide by its top bit.
      ST_P_CHK: begin
        if (b4_zero) begin
          emit      = out_free;
          emit_kind = ACT_PRESS;
          emit_err  = 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_a         = t2_q[ValW-1] ? t2_q : (t2_q << 1);
          div_b         = b4_q;
          post_sh_d     = t2_q[ValW-1];
        end
      end
      ST_P_DIV: begin
        if (div_stat.done) p_d = post_sh_q ? (div_q << 1) : div_q;
      end
      ST_P_S1: begin
        mul_a = asr32(p_q, 5'd8);
        mul_b = asr32(p_q, 5'd8);
        t1_d  = mul_p;
      end
      ST_P_S2: begin
        mul_a = t1_q;
        mul_b = P_SQ_COEFF;
        t1_d  = asr32(mul_p, 5'd16);
      end
      ST_P_S3: begin
        mul_a = p_q;
        mul_b = P_LIN_COEFF;
        t2_d  = asr32(mul_p, 5'd16);
      end
      ST_P_FIN: begin
        emit      = out_free;
        emit_kind = ACT_PRESS;
        emit_val  = p_q + asr32(t1_q + t2_q + P_OFFSET, 5'd4);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      temp_term_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      temp_term_q <= temp_term_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    b6_q      <= b6_d;
    sq_q      <= sq_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    b3_q      <= b3_d;
    b4_q      <= b4_d;
    p_q       <= p_d;
    post_sh_q <= post_sh_d;
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_value_q <= emit_val;
      out_err_q   <= emit_err;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.value     = out_value_q;
  assign out_o.div_error = out_err_q;

  // A new result is only written into a free output register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written over a pending transaction");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_T_DIV || state_q == ST_P_DIV))
    else $error("divider finished outside a divide step");

  // No item is taken while a division is still running.
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !div_stat.busy)
    else $error("transaction accepted during a division");

  // A division error always comes with a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.div_error) |-> (out_o.value == '0))
    else $error("division error with a nonzero value");

endmodule
